[src/sorted_priority_queue_assert.svh]
// Assertion macros shared by the priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/spq_pkg.sv]
// Types and constants of the sorted priority queue.
package spq_pkg;

    localparam int DATA_W = 8;
    localparam int PRIO_W = 8;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    // result tdata layout, lowest bit first
    localparam int OUT_DATA_LSB = 0;
    localparam int OUT_STAT_LSB = OUT_DATA_LSB + DATA_W;
    localparam int OUT_CNT_LSB  = OUT_STAT_LSB + STAT_W;
    localparam int OUT_TDATA_W  = 16;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } spq_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    // command broadcast to every cell
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } spq_cmd_t;

endpackage

[src/spq_cell.sv]
// One slot of the sorted chain: holds an item and shifts with its neighbors.
module spq_cell
(
    input  logic                          clk,
    input  spq_pkg::spq_cmd_t             cmd,
    input  logic                          occupied,
    input  logic                          left_ge,
    input  logic [spq_pkg::DATA_W-1:0]    left_data,
    input  logic [spq_pkg::PRIO_W-1:0]    left_prio,
    input  logic [spq_pkg::DATA_W-1:0]    right_data,
    input  logic [spq_pkg::PRIO_W-1:0]    right_prio,
    output logic                          ge,
    output logic [spq_pkg::DATA_W-1:0]    data,
    output logic [spq_pkg::PRIO_W-1:0]    prio,
    output logic [spq_pkg::DATA_W-1:0]    data_next
);

    logic [spq_pkg::DATA_W-1:0] data_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_next;

    // item stays ahead of the new one (equal priority keeps arrival order)
    assign ge = occupied && (prio_reg >= cmd.prio);

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (cmd.enq)
        begin
            if (!ge)
            begin
                if (left_ge)
                begin
                    data_next = cmd.data;
                    prio_next = cmd.prio;
                end
                else
                begin
                    data_next = left_data;
                    prio_next = left_prio;
                end
            end
        end
        else if (cmd.deq)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

[src/sorted_priority_queue.sv]
// Sorted priority queue built as a chain of shifting slot cells.
//
// Holds up to DEPTH byte items ordered by priority, highest at the front,
// equal priorities first in, first out. Every request beat (tuser 0 enqueue,
// 1 dequeue) returns one result beat with the front item, the status and the
// count after the operation. One request is taken per cycle unless the output
// stalls; the result appears in the cycle after its request. Each cell compares
// its own priority with the incoming one and shifts toward its neighbor in the
// same cycle, so that compare plus the cell-0 select path sets the clock period.
// The result register decouples the sides: a new request is taken while the
// previous result waits, as long as that result is taken in the same cycle.
module sorted_priority_queue #(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // item_data[7:0], item_priority[15:8]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // front_data[7:0], status[9:8],
                                        // item_count[14:10], zero[15]
    output logic        m_axis_tuser    // front_valid
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                       accept;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       full;
    logic                       empty;
    spq_pkg::spq_cmd_t          cmd;
    spq_pkg::spq_status_t       status;

    logic [spq_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [spq_pkg::PRIO_W-1:0] cell_prio [DEPTH];
    logic [spq_pkg::DATA_W-1:0] cell_data_next [DEPTH];
    logic [DEPTH-1:0]           cell_ge;

    logic                       out_valid_reg;
    logic [spq_pkg::DATA_W-1:0] out_data_reg;
    logic                       out_front_reg;
    spq_pkg::spq_status_t       out_status_reg;
    logic [spq_pkg::CNT_W-1:0]  out_count_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CW'(DEPTH));
    assign empty         = (count_reg == '0);

    always_comb
    begin
        cmd.enq    = 1'b0;
        cmd.deq    = 1'b0;
        cmd.data   = s_axis_tdata[7:0];
        cmd.prio   = s_axis_tdata[15:8];
        status     = spq_pkg::ST_OK;
        count_next = count_reg;
        if (accept)
        begin
            if (s_axis_tuser == spq_pkg::OP_ENQ)
            begin
                if (full)
                begin
                    status = spq_pkg::ST_FULL;
                end
                else
                begin
                    cmd.enq    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.deq    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                       occ;
        logic                       l_ge;
        logic [spq_pkg::DATA_W-1:0] l_data;
        logic [spq_pkg::PRIO_W-1:0] l_prio;
        logic [spq_pkg::DATA_W-1:0] r_data;
        logic [spq_pkg::PRIO_W-1:0] r_prio;

        assign occ = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            // front cell: the new item lands here unless the front item's priority is equal or higher
            assign l_ge   = 1'b1;
            assign l_data = cmd.data;
            assign l_prio = cmd.prio;
        end
        else
        begin : g_body
            assign l_ge   = cell_ge[i-1];
            assign l_data = cell_data[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_data = cell_data[i];
            assign r_prio = cell_prio[i];
        end
        else
        begin : g_mid
            assign r_data = cell_data[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (occ),
            .left_ge    (l_ge),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .right_data (r_data),
            .right_prio (r_prio),
            .ge         (cell_ge[i]),
            .data       (cell_data[i]),
            .prio       (cell_prio[i]),
            .data_next  (cell_data_next[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_front_reg  <= (count_next != '0);
            out_data_reg   <= (count_next != '0) ? cell_data_next[0] : '0;
            out_status_reg <= status;
            out_count_reg  <= spq_pkg::CNT_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_front_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_status_reg, out_data_reg};

endmodule

[src/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_assert.svh"

module spq_checker #(
    parameter int DEPTH = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic                      beat;
    logic [spq_pkg::STAT_W-1:0] stat;
    logic [spq_pkg::CNT_W-1:0]  cnt;
    logic [spq_pkg::DATA_W-1:0] fdata;

    assign beat  = m_axis_tvalid && m_axis_tready;
    assign fdata = m_axis_tdata[spq_pkg::OUT_DATA_LSB +: spq_pkg::DATA_W];
    assign stat  = m_axis_tdata[spq_pkg::OUT_STAT_LSB +: spq_pkg::STAT_W];
    assign cnt   = m_axis_tdata[spq_pkg::OUT_CNT_LSB +: spq_pkg::CNT_W];

    `SPQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")

    `SPQ_ASSERT_NOW(a_front_cnt, beat, m_axis_tuser == (cnt != '0),
        "front valid disagrees with count")

    `SPQ_ASSERT_NOW(a_full, beat && stat == spq_pkg::ST_FULL,
        cnt == spq_pkg::CNT_W'(DEPTH) && m_axis_tuser,
        "full status with queue not full")

    `SPQ_ASSERT_NOW(a_empty, beat && stat == spq_pkg::ST_EMPTY,
        cnt == '0 && fdata == '0 && !m_axis_tuser,
        "empty status with items held")

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
